/* rtl/command_replay_guard_macros.svh */
// Assertion macros shared by the replay guard RTL.
`ifndef COMMAND_REPLAY_GUARD_MACROS_SVH
`define COMMAND_REPLAY_GUARD_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define CRG_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("replay guard assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define CRG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("replay guard assertion failed");
`else
`define CRG_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define CRG_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

/* rtl/crg_pkg.sv */
// Package for the replay guard: constants, status codes and a helper function.
`timescale 1ns / 1ps
package crg_pkg;

    localparam int HISTORY_DEPTH_DEF = 8;
    localparam int NONCE_BYTES_DEF   = 8;

    localparam int STAMP_W  = 64;
    localparam int NONCE_W  = 64;
    localparam int LENGTH_W = 4;
    localparam int WINDOW_W = 32;
    localparam int CFG_IDX_W = 4;

    localparam logic [WINDOW_W-1:0] REPLAY_WINDOW_RESET = 32'd60000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REPLAY_WINDOW = 4'd0,
        CFG_KEY_LOADED    = 4'd1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CLEARED   = 3'd1,
        ST_NO_KEY    = 3'd2,
        ST_STALE     = 3'd3,
        ST_MALFORMED = 3'd4,
        ST_REPLAYED  = 3'd5,
        ST_BAD_MAC   = 3'd6
    } status_t;

    // Keep the first len bytes of the nonce, counted from the top byte.
    function automatic logic [NONCE_W-1:0] nonce_mask(input logic [LENGTH_W-1:0] len);
        logic [NONCE_W-1:0] mask;
        mask = '0;
        for (int b = 0; b < NONCE_W / 8; b++) begin
            if (LENGTH_W'(b) < len) begin
                mask[NONCE_W-1-8*b -: 8] = 8'hFF;
            end
        end
        return mask;
    endfunction

endpackage

/* rtl/command_replay_guard.sv */
// Replay guard top level: nonce history memory and check sequencer.
`timescale 1ns / 1ps
`include "command_replay_guard_macros.svh"
// Usage:
//   Input channel s_* carries one command check (or a clear action) per transfer.
//   Result channel m_* returns one transfer per input: m_accepted and m_status.
//   Configuration channel cfg_* writes replay_window (index 0) or key_loaded
//   (index 1); it is always ready. Write it only while the block is idle.
// Sequence: clear, no-key, stale and malformed items pass from the check step
//   straight to the response step. Items that reach the nonce test also scan
//   the history memory one entry per cycle, then pass the tail and commit
//   steps before the response step. The single read port of the history memory
//   sets the scan rate: one slot is fetched and compared per cycle.
// Throughput: one item in flight at a time; s_ready is high only in idle, so
//   the next item follows as soon as the result is loaded into the output
//   register, even while that result still waits for m_ready.
// Reset: aresetn (synchronous, active low) empties the history, forgets the
//   newest timestamp, sets replay_window to 60000 and key_loaded to 0.
// Stall: a result held by a low m_ready blocks only the next result; the
//   sequencer waits in its response step until the output register frees up.
module command_replay_guard #(
    parameter int HISTORY_DEPTH = crg_pkg::HISTORY_DEPTH_DEF,
    parameter int NONCE_BYTES   = crg_pkg::NONCE_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [crg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crg_pkg::WINDOW_W-1:0]   cfg_data,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_action,
    input  logic [crg_pkg::STAMP_W-1:0]    s_stamp,
    input  logic [crg_pkg::NONCE_W-1:0]    s_nonce_value,
    input  logic [crg_pkg::LENGTH_W-1:0]   s_nonce_length,
    input  logic                           s_well_formed,
    input  logic                           s_mac_match,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_accepted,
    output logic [2:0]                     m_status
);
    import crg_pkg::*;

    // Stored nonce keeps only the bytes that may be valid; the rest are zero.
    localparam int NW      = 8 * NONCE_BYTES;
    localparam int ENTRY_W = NW + LENGTH_W + STAMP_W;
    localparam int IDX_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);
    localparam logic [LENGTH_W-1:0] MAX_LEN = LENGTH_W'(NONCE_BYTES);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_SCAN   = 6'b000100,
        S_TAIL   = 6'b001000,
        S_COMMIT = 6'b010000,
        S_RESP   = 6'b100000
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                  state_reg, state_next;
    logic [WINDOW_W-1:0]     window_reg, window_next;
    logic                    key_reg, key_next;
    logic [STAMP_W-1:0]      newest_reg, newest_next;
    logic [HISTORY_DEPTH-1:0] valid_reg, valid_next;

    // captured item
    logic                    action_reg, action_next;
    logic [STAMP_W-1:0]      stamp_reg, stamp_next;
    logic [NONCE_W-1:0]      nonce_reg, nonce_next;
    logic [LENGTH_W-1:0]     len_reg, len_next;
    logic                    formed_reg, formed_next;
    logic                    mac_reg, mac_next;

    // scan bookkeeping
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]        cmp_idx_reg, cmp_idx_next;
    logic                    match_reg, match_next;
    logic                    free_found_reg, free_found_next;
    logic [IDX_W-1:0]        free_idx_reg, free_idx_next;
    logic                    old_found_reg, old_found_next;
    logic [IDX_W-1:0]        old_idx_reg, old_idx_next;
    logic [STAMP_W-1:0]      old_stamp_reg, old_stamp_next;

    status_t                 status_reg, status_next;

    // result register
    logic                    m_valid_reg, m_valid_next;
    logic                    m_accepted_reg, m_accepted_next;
    logic [2:0]              m_status_reg, m_status_next;

    // ------------------------------------------------------------------
    // History memory: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0]      hist_mem [HISTORY_DEPTH];
    logic [ENTRY_W-1:0]      rd_entry_reg;
    logic                    mem_re;
    logic                    mem_we;
    logic [IDX_W-1:0]        wr_idx;
    logic [ENTRY_W-1:0]      wr_entry;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[wr_idx] <= wr_entry;
        end
        if (mem_re) begin
            rd_entry_reg <= hist_mem[rd_idx_reg];
        end
    end

    logic [NW-1:0]           rd_nonce;
    logic [LENGTH_W-1:0]     rd_len;
    logic [STAMP_W-1:0]      rd_stamp;
    logic                    rd_slot_valid;

    assign rd_nonce      = rd_entry_reg[ENTRY_W-1 -: NW];
    assign rd_len        = rd_entry_reg[STAMP_W +: LENGTH_W];
    assign rd_stamp      = rd_entry_reg[STAMP_W-1:0];
    assign rd_slot_valid = valid_reg[cmp_idx_reg];

    // ------------------------------------------------------------------
    // Freshness test, evaluated in the check step
    // ------------------------------------------------------------------
    logic [STAMP_W:0]        stamp_sum;
    logic                    stale;
    logic                    malformed;

    // 65-bit sum: a sum past 64 bits can never be stale.
    assign stamp_sum = {1'b0, stamp_reg} + {{(STAMP_W + 1 - WINDOW_W){1'b0}}, window_reg};
    assign stale     = (newest_reg != '0) && (stamp_sum < {1'b0, newest_reg});
    assign malformed = !formed_reg || (len_reg == '0) || (len_reg > MAX_LEN);

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_accepted = m_accepted_reg;
    assign m_status   = m_status_reg;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        window_next     = window_reg;
        key_next        = key_reg;
        newest_next     = newest_reg;
        valid_next      = valid_reg;
        action_next     = action_reg;
        stamp_next      = stamp_reg;
        nonce_next      = nonce_reg;
        len_next        = len_reg;
        formed_next     = formed_reg;
        mac_next        = mac_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = rd_idx_reg;
        match_next      = match_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        old_found_next  = old_found_reg;
        old_idx_next    = old_idx_reg;
        old_stamp_next  = old_stamp_reg;
        status_next     = status_reg;
        m_valid_next    = m_valid_reg;
        m_accepted_next = m_accepted_reg;
        m_status_next   = m_status_reg;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        wr_idx          = free_found_reg ? free_idx_reg : old_idx_reg;
        wr_entry        = {nonce_reg[NONCE_W-1 -: NW], len_reg, stamp_reg};

        // drop the result once the receiver takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // configuration writes; indexes past the list are ignored
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_REPLAY_WINDOW: window_next = cfg_data;
                CFG_KEY_LOADED:    key_next    = cfg_data[0];
                default:           ;
            endcase
        end

        // compare stage: one history entry per cycle
        if (cmp_vld_reg) begin
            if (rd_slot_valid && (rd_len == len_reg) &&
                (rd_nonce == nonce_reg[NONCE_W-1 -: NW])) begin
                match_next = 1'b1;
            end
            if (!rd_slot_valid && !free_found_reg) begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
            if (rd_slot_valid && (!old_found_reg || (rd_stamp < old_stamp_reg))) begin
                old_found_next = 1'b1;
                old_idx_next   = cmp_idx_reg;
                old_stamp_next = rd_stamp;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    action_next = s_action;
                    stamp_next  = s_stamp;
                    nonce_next  = s_nonce_value;
                    len_next    = s_nonce_length;
                    formed_next = s_well_formed;
                    mac_next    = s_mac_match;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                rd_idx_next     = '0;
                match_next      = 1'b0;
                free_found_next = 1'b0;
                old_found_next  = 1'b0;
                nonce_next      = nonce_reg & nonce_mask(len_reg);
                if (action_reg) begin
                    valid_next  = '0;
                    newest_next = '0;
                    status_next = ST_CLEARED;
                    state_next  = S_RESP;
                end else if (!key_reg) begin
                    status_next = ST_NO_KEY;
                    state_next  = S_RESP;
                end else if (stale) begin
                    status_next = ST_STALE;
                    state_next  = S_RESP;
                end else begin
                    // advance the newest stamp even if a later test fails
                    if ((newest_reg == '0) || (stamp_reg > newest_reg)) begin
                        newest_next = stamp_reg;
                    end
                    if (malformed) begin
                        status_next = ST_MALFORMED;
                        state_next  = S_RESP;
                    end else begin
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                mem_re       = 1'b1;
                cmp_vld_next = 1'b1;
                cmp_idx_next = rd_idx_reg;
                rd_idx_next  = rd_idx_reg + IDX_W'(1);
                if (rd_idx_reg == LAST_IDX) begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL: begin
                // last entry is compared in this cycle
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (match_reg) begin
                    status_next = ST_REPLAYED;
                end else if (!mac_reg) begin
                    status_next = ST_BAD_MAC;
                end else begin
                    mem_we             = 1'b1;
                    valid_next[wr_idx] = 1'b1;
                    status_next        = ST_OK;
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_accepted_next = (status_reg == ST_OK);
                    m_status_next   = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            window_reg  <= REPLAY_WINDOW_RESET;
            key_reg     <= 1'b0;
            newest_reg  <= '0;
            valid_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            window_reg  <= window_next;
            key_reg     <= key_next;
            newest_reg  <= newest_next;
            valid_reg   <= valid_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg     <= action_next;
        stamp_reg      <= stamp_next;
        nonce_reg      <= nonce_next;
        len_reg        <= len_next;
        formed_reg     <= formed_next;
        mac_reg        <= mac_next;
        rd_idx_reg     <= rd_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        match_reg      <= match_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        old_found_reg  <= old_found_next;
        old_idx_reg    <= old_idx_next;
        old_stamp_reg  <= old_stamp_next;
        status_reg     <= status_next;
        m_accepted_reg <= m_accepted_next;
        m_status_reg   <= m_status_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A nonce is recorded only when it was not found and the MAC matched.
    `CRG_ASSERT_IMPLIES(a_write_only_fresh, aclk, aresetn, mem_we, !match_reg && mac_reg)
    // A clear action leaves the history empty and no timestamp seen.
    `CRG_ASSERT_NEXT(a_clear_empties, aclk, aresetn, (state_reg == S_CHECK) && action_reg, (valid_reg == '0) && (newest_reg == '0))
    // Compare stage runs only while the scan is in progress.
    `CRG_ASSERT_IMPLIES(a_cmp_in_scan, aclk, aresetn, cmp_vld_reg, (state_reg == S_SCAN) || (state_reg == S_TAIL))
    // A full history must have a candidate slot to replace.
    `CRG_ASSERT_IMPLIES(a_victim_known, aclk, aresetn, mem_we, free_found_reg || old_found_reg)

endmodule

/* test/tb_command_replay_guard.sv */
// Self-checking testbench for command_replay_guard: directed script, random phases, scoreboard.
`timescale 1ns / 1ps
module tb_command_replay_guard;
    import crg_pkg::*;

    // Cycles without any transfer before the run is declared hung. The slowest
    // correct item is a sender gap, a history scan and a result stall, so this is
    // many times over.
    localparam int STALL_LIMIT = 4000;
    // Cycles to keep watching the result channel once nothing is awaited.
    localparam int DRAIN_CYCLES = 20;
    localparam int SLOTS = 8;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS = 100;
    localparam int POOL_SIZE = 12;

    typedef struct packed {
        logic        action;
        logic [63:0] stamp;
        logic [63:0] nonce;
        logic [3:0]  nonce_size;
        logic        formed;
        logic        mac_ok;
    } command_t;

    typedef struct packed {
        logic    accepted;
        status_t status;
    } verdict_t;

    typedef enum logic {
        ROW_CMD,
        ROW_REG
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        cfg_index_t  reg_idx;
        logic [31:0] reg_val;
        command_t    cmd;
        bit          typed;
        status_t     typed_status;
    } script_row_t;

    // Clock, reset and block inputs, all known from time zero.
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_REPLAY_WINDOW;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = 1'b0;
    logic [63:0] s_stamp = '0;
    logic [63:0] s_nonce_value = '0;
    logic [3:0]  s_nonce_length = '0;
    logic        s_well_formed = 1'b0;
    logic        s_mac_match = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_accepted;
    logic [2:0]  m_status;

    // Shadow of the guard: registers and nonce history.
    logic [31:0] window_ms;
    logic        key_present;
    logic        hist_valid [SLOTS];
    logic [63:0] hist_nonce [SLOTS];
    logic [3:0]  hist_len   [SLOTS];
    logic [63:0] hist_stamp [SLOTS];
    logic [63:0] latest_stamp;

    verdict_t    awaited_verdicts[$];
    script_row_t script[$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          ready_hold = 0;
    bit          calm_tail = 1'b0;

    command_replay_guard uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_stamp        (s_stamp),
        .s_nonce_value  (s_nonce_value),
        .s_nonce_length (s_nonce_length),
        .s_well_formed  (s_well_formed),
        .s_mac_match    (s_mac_match),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_accepted     (m_accepted),
        .m_status       (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Bytes past the nonce length do not take part in the replay test.
    function automatic logic [63:0] leading_bytes(input logic [3:0] len);
        logic [63:0] mask;
        mask = '1;
        return mask << (64 - 8 * int'(len));
    endfunction

    function automatic void forget_history();
        for (int i = 0; i < SLOTS; i++) begin
            hist_valid[i] = 1'b0;
            hist_nonce[i] = '0;
            hist_len[i] = '0;
            hist_stamp[i] = '0;
        end
        latest_stamp = '0;
    endfunction

    // Decide one command and advance the shadow state the way the guard does.
    function automatic status_t guard_verdict(input command_t c);
        logic [64:0] reach;
        logic [63:0] trimmed;
        logic        fresh;
        logic        seen;
        int          victim;
        status_t     st;
        fresh = 1'b1;
        seen = 1'b0;
        victim = -1;
        if (c.action) begin
            forget_history();
            st = ST_CLEARED;
        end else if (!key_present) begin
            st = ST_NO_KEY;
        end else begin
            // A zero newest stamp means none seen: take any stamp as is.
            if (latest_stamp == '0) begin
                latest_stamp = c.stamp;
            end else begin
                // Widen by one bit so the sum never wraps.
                reach = {1'b0, c.stamp} + {33'b0, window_ms};
                if (reach < {1'b0, latest_stamp}) begin
                    fresh = 1'b0;
                end else if (c.stamp > latest_stamp) begin
                    latest_stamp = c.stamp;
                end
            end
            if (!fresh) begin
                st = ST_STALE;
            end else if (!c.formed || c.nonce_size == 0 || c.nonce_size > 8) begin
                st = ST_MALFORMED;
            end else begin
                trimmed = c.nonce & leading_bytes(c.nonce_size);
                for (int i = 0; i < SLOTS; i++) begin
                    if (hist_valid[i] && hist_len[i] == c.nonce_size
                            && hist_nonce[i] == trimmed) begin
                        seen = 1'b1;
                    end
                end
                if (seen) begin
                    st = ST_REPLAYED;
                end else if (!c.mac_ok) begin
                    st = ST_BAD_MAC;
                end else begin
                    // First free slot, else the oldest stamp, lowest index on ties.
                    for (int i = 0; i < SLOTS; i++) begin
                        if (victim < 0 && !hist_valid[i]) begin
                            victim = i;
                        end
                    end
                    if (victim < 0) begin
                        victim = 0;
                        for (int i = 1; i < SLOTS; i++) begin
                            if (hist_stamp[i] < hist_stamp[victim]) begin
                                victim = i;
                            end
                        end
                    end
                    hist_valid[victim] = 1'b1;
                    hist_nonce[victim] = trimmed;
                    hist_len[victim] = c.nonce_size;
                    hist_stamp[victim] = c.stamp;
                    st = ST_OK;
                end
            end
        end
        return st;
    endfunction

    // Present one command, hold it until the transfer, then queue its verdict.
    // A typed status overrides the shadow's answer; the shadow still runs.
    task automatic send_command(input command_t c, input bit typed, input status_t typed_st);
        verdict_t v;
        s_valid <= 1'b1;
        s_action <= c.action;
        s_stamp <= c.stamp;
        s_nonce_value <= c.nonce;
        s_nonce_length <= c.nonce_size;
        s_well_formed <= c.formed;
        s_mac_match <= c.mac_ok;
        do @(posedge aclk); while (!s_ready);
        v.status = guard_verdict(c);
        if (typed) begin
            v.status = typed_st;
        end
        v.accepted = (v.status == ST_OK);
        awaited_verdicts.push_back(v);
    endtask

    // Register writes go in only once every awaited result has left the block.
    task automatic write_register(input cfg_index_t idx, input logic [31:0] val);
        s_valid <= 1'b0;
        while (awaited_verdicts.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        // Let the drop settle before anything else drives the channel.
        @(posedge aclk);
        if (idx == CFG_REPLAY_WINDOW) begin
            window_ms = val;
        end else begin
            key_present = val[0];
        end
    endtask

    function automatic void plan_command(input logic action, input logic [63:0] stamp,
                                         input logic [63:0] nonce, input logic [3:0] len,
                                         input logic formed, input logic mac_ok,
                                         input bit typed, input status_t typed_st);
        script_row_t r;
        r.kind = ROW_CMD;
        r.reg_idx = CFG_REPLAY_WINDOW;
        r.reg_val = '0;
        r.cmd = '{action, stamp, nonce, len, formed, mac_ok};
        r.typed = typed;
        r.typed_status = typed_st;
        script.push_back(r);
    endfunction

    function automatic void plan_register(input cfg_index_t idx, input logic [31:0] val);
        script_row_t r;
        r.kind = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        r.cmd = '0;
        r.typed = 1'b0;
        r.typed_status = ST_OK;
        script.push_back(r);
    endfunction

    // Result sink: stall in random bursts, none in the tail.
    always @(posedge aclk) begin
        if (!aresetn || calm_tail) begin
            m_ready <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            ready_hold <= $urandom_range(1, 14) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Scoreboard: compare each result transfer with the oldest awaited verdict.
    always @(posedge aclk) begin : result_check
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_verdicts.size() == 0) begin
                flag_mismatch($sformatf("result with nothing awaited: accepted=%0d status=%0d",
                                        m_accepted, m_status));
            end else begin
                want = awaited_verdicts.pop_front();
                if (m_accepted !== want.accepted) begin
                    flag_mismatch($sformatf("accepted=%0d, want %0d (status want %0d)",
                                            m_accepted, want.accepted, want.status));
                end
                if (m_status !== want.status) begin
                    flag_mismatch($sformatf("status=%0d, want %0d", m_status, want.status));
                end
            end
        end
    end

    // Watchdog: count cycles in which no channel transfers anything.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        command_t    c;
        logic [63:0] nonce_pool [POOL_SIZE];
        logic [3:0]  pool_len   [POOL_SIZE];
        logic [63:0] clock_ms;
        logic [63:0] keep;
        int          lag;
        int          pick;
        int          roll;

        // Shadow state matches the block after reset.
        window_ms = REPLAY_WINDOW_RESET;
        key_present = 1'b0;
        forget_history();

        // Directed script. Statuses typed in are the obvious ones; the
        // rest come from the shadow model.
        plan_command(1'b0, 64'd1000, 64'hA5A5_0001_0203_0405, 4'd8, 1'b1, 1'b1, 1, ST_NO_KEY);
        plan_register(CFG_KEY_LOADED, 32'd1);
        // A zero stamp leaves the guard with no newest stamp.
        plan_command(1'b0, 64'd0, 64'hA5A5_0001_0203_0405, 4'd8, 1'b1, 1'b1, 0, ST_OK);
        plan_command(1'b0, 64'd100000, 64'h5A5A_F0E1_D2C3_B4A5, 4'd8, 1'b1, 1'b1, 0, ST_OK);
        // One past the window is stale, exactly at the window is fresh.
        plan_command(1'b0, 64'd39999, 64'h0F1E_2D3C_4B5A_6978, 4'd8, 1'b1, 1'b1, 1, ST_STALE);
        plan_command(1'b0, 64'd40000, 64'h0F1E_2D3C_4B5A_6978, 4'd8, 1'b1, 1'b1, 0, ST_OK);
        plan_command(1'b0, 64'd100001, 64'hDEAD_BEEF_0000_0001, 4'd8, 1'b0, 1'b1, 1,
                     ST_MALFORMED);
        plan_command(1'b0, 64'd100001, 64'hDEAD_BEEF_0000_0002, 4'd0, 1'b1, 1'b1, 1,
                     ST_MALFORMED);
        plan_command(1'b0, 64'd100001, 64'hDEAD_BEEF_0000_0003, 4'd9, 1'b1, 1'b1, 1,
                     ST_MALFORMED);
        plan_command(1'b0, 64'd100001, 64'hDEAD_BEEF_0000_0004, 4'd15, 1'b1, 1'b1, 1,
                     ST_MALFORMED);
        plan_command(1'b0, 64'd100002, 64'h5A5A_F0E1_D2C3_B4A5, 4'd8, 1'b1, 1'b1, 1,
                     ST_REPLAYED);
        // One-byte nonce; the replay ignores the bytes past the length.
        plan_command(1'b0, 64'd100003, 64'h1122_3344_5566_7788, 4'd1, 1'b1, 1'b1, 0, ST_OK);
        plan_command(1'b0, 64'd100004, 64'h11FF_FFFF_FFFF_FFFF, 4'd1, 1'b1, 1'b1, 1,
                     ST_REPLAYED);
        plan_command(1'b0, 64'd100005, 64'hC0FF_EE00_1234_5678, 4'd8, 1'b1, 1'b0, 1,
                     ST_BAD_MAC);
        plan_command(1'b1, 64'hFFFF_0000_FFFF_0000, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 1'b1,
                     1, ST_CLEARED);
        // Largest stamp after a clear, then the smallest one is stale.
        plan_command(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hA5A5_0001_0203_0405, 4'd8, 1'b1, 1'b1,
                     0, ST_OK);
        plan_command(1'b0, 64'd0, 64'h5A5A_F0E1_D2C3_B4A5, 4'd8, 1'b1, 1'b1, 1, ST_STALE);
        // Widest window: sums at, below and beyond 64 bits.
        plan_register(CFG_REPLAY_WINDOW, 32'hFFFF_FFFF);
        plan_command(1'b0, 64'hFFFF_FFFF_0000_0000, 64'h0F1E_2D3C_4B5A_6978, 4'd8, 1'b1, 1'b1,
                     0, ST_OK);
        plan_command(1'b0, 64'hFFFF_FFFE_FFFF_FFFF, 64'h1122_3344_5566_7788, 4'd8, 1'b1, 1'b1,
                     0, ST_OK);
        plan_command(1'b0, 64'hFFFF_FFFF_FFFF_FF00, 64'hDEAD_BEEF_0000_0005, 4'd8, 1'b1, 1'b1,
                     0, ST_OK);
        // Zero window: only stamps at or above the newest pass.
        plan_register(CFG_REPLAY_WINDOW, 32'd0);
        plan_command(1'b1, 64'd0, 64'd0, 4'd0, 1'b0, 1'b0, 1, ST_CLEARED);
        plan_command(1'b0, 64'd5000, 64'hA5A5_0001_0203_0405, 4'd8, 1'b1, 1'b1, 0, ST_OK);
        plan_command(1'b0, 64'd4999, 64'h5A5A_F0E1_D2C3_B4A5, 4'd8, 1'b1, 1'b1, 1, ST_STALE);
        plan_command(1'b0, 64'd5000, 64'h5A5A_F0E1_D2C3_B4A5, 4'd8, 1'b1, 1'b1, 0, ST_OK);
        plan_register(CFG_KEY_LOADED, 32'd0);
        plan_command(1'b0, 64'd6000, 64'h0F1E_2D3C_4B5A_6978, 4'd8, 1'b1, 1'b1, 1, ST_NO_KEY);

        // Hold reset, then release it at a rising edge.
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the script; the sender idles now and then between commands.
        foreach (script[i]) begin
            if (script[i].kind == ROW_REG) begin
                write_register(script[i].reg_idx, script[i].reg_val);
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 14)) @(posedge aclk);
                end
                send_command(script[i].cmd, script[i].typed, script[i].typed_status);
            end
        end

        // Random phases. A small nonce pool keeps replays and history
        // evictions frequent; stamps follow a running clock with jitter.
        for (int i = 0; i < POOL_SIZE; i++) begin
            nonce_pool[i] = {$urandom, $urandom};
            pool_len[i] = 4'($urandom_range(1, 8));
        end
        clock_ms = 64'd1_000_000 + $urandom_range(0, 100000);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: write_register(CFG_REPLAY_WINDOW, REPLAY_WINDOW_RESET);
                1: write_register(CFG_REPLAY_WINDOW, 32'd0);
                2: write_register(CFG_REPLAY_WINDOW, 32'hFFFF_FFFF);
                3: write_register(CFG_REPLAY_WINDOW, $urandom_range(1, 2000));
                4: write_register(CFG_REPLAY_WINDOW, $urandom);
                default: write_register(CFG_REPLAY_WINDOW, $urandom_range(500, 5000));
            endcase
            // Upper data bits do not matter to the key flag; toggle them anyway.
            write_register(CFG_KEY_LOADED,
                           {31'($urandom), 1'((phase != 4) | $urandom_range(0, 1))});
            // Drop all idling in the last phase.
            calm_tail = (phase == RANDOM_PHASES - 1);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (!calm_tail && $urandom_range(0, 4) == 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 14)) @(posedge aclk);
                end

                lag = (window_ms < 20000) ? 2 * int'(window_ms) + 2 : 20000;
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    c.stamp = clock_ms + 64'($urandom_range(0, 200)) - 64'($urandom_range(0, lag));
                end else if (roll < 84) begin
                    c.stamp = clock_ms;
                end else if (roll < 95 && latest_stamp > {32'b0, window_ms}) begin
                    // Straddle the stale boundary.
                    c.stamp = latest_stamp - window_ms - $urandom_range(0, 1);
                end else if (roll < 98) begin
                    c.stamp = {$urandom, $urandom};
                end else begin
                    c.stamp = '0;
                end

                if ($urandom_range(0, 1) == 0) begin
                    // Pool nonce with random bytes past its length.
                    pick = $urandom_range(0, POOL_SIZE - 1);
                    c.nonce_size = pool_len[pick];
                    keep = leading_bytes(c.nonce_size);
                    c.nonce = (nonce_pool[pick] & keep) | ({$urandom, $urandom} & ~keep);
                end else begin
                    c.nonce_size = 4'($urandom_range(1, 8));
                    c.nonce = {$urandom, $urandom};
                end
                if ($urandom_range(0, 19) == 0) begin
                    c.nonce_size = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
                end
                c.formed = ($urandom_range(0, 19) != 0);
                c.mac_ok = ($urandom_range(0, 11) != 0);
                c.action = ($urandom_range(0, 19) == 0);

                send_command(c, 0, ST_OK);
                clock_ms = clock_ms + $urandom_range(0, 3000);
            end
        end

        // Drain: wait for every awaited result, then watch a little longer.
        s_valid <= 1'b0;
        while (awaited_verdicts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/crg_pkg.sv
rtl/command_replay_guard.sv
test/tb_command_replay_guard.sv
